FILE: rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// shared types, codes and constants of the banker's safety check
// ----------------------------------------------------------------------------
package bsc_pkg;

  // default sizes
  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 8;
  localparam int DEF_VALUE_WIDTH   = 16;

  // fixed field widths
  localparam int ACTION_W     = 2;
  localparam int PROC_INDEX_W = 4;
  localparam int RES_INDEX_W  = 3;
  localparam int PROC_COUNT_W = 5;
  localparam int RES_COUNT_W  = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;

  // work vector entries saturate at this width
  localparam int WORK_W = 21;
  localparam logic [WORK_W-1:0] WORK_MAX = '1;

  // register reset values
  localparam logic [PROC_COUNT_W-1:0] PROC_COUNT_RST = PROC_COUNT_W'(16);
  localparam logic [RES_COUNT_W-1:0]  RES_COUNT_RST  = RES_COUNT_W'(8);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD_PAIR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_FREE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK     = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PROC_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RES_COUNT  = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_PROC,
    S_FIT_RD,
    S_FIT_CHK,
    S_ADD_RD,
    S_ADD_WR,
    S_GRANT,
    S_NEXT,
    S_VERDICT
  } bsc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_pair;
    logic load_free;
    logic init;
    logic p_clear;
    logic p_inc;
    logic r_clear;
    logic r_inc;
    logic add_work;
    logic grant;
    logic verdict;
  } bsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic np_zero;
    logic nr_zero;
    logic flag_set;
    logic fits;
    logic last_p;
    logic last_r;
    logic all_done;
    logic progress;
  } bsc_stat_t;

endpackage

FILE: rtl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// sequencer of the safety check: walks processes and resources
// ----------------------------------------------------------------------------
module bsc_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [bsc_pkg::ACTION_W-1:0]      action,
  input  bsc_pkg::bsc_stat_t                stat,
  output bsc_pkg::bsc_cmd_t                 cmd,
  output logic                              busy
);
  import bsc_pkg::*;

  bsc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && action == ACT_CHECK) state_next = S_INIT;
      end
      S_INIT: begin
        state_next = stat.np_zero ? S_VERDICT : S_PROC;
      end
      S_PROC: begin
        if (stat.flag_set)     state_next = S_NEXT;
        else if (stat.nr_zero) state_next = S_GRANT;
        else                   state_next = S_FIT_RD;
      end
      S_FIT_RD: begin
        state_next = S_FIT_CHK;
      end
      S_FIT_CHK: begin
        if (!stat.fits)       state_next = S_NEXT;
        else if (stat.last_r) state_next = S_ADD_RD;
        else                  state_next = S_FIT_RD;
      end
      S_ADD_RD: begin
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        state_next = stat.last_r ? S_GRANT : S_ADD_RD;
      end
      S_GRANT: begin
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (!stat.last_p)                        state_next = S_PROC;
        else if (stat.all_done || !stat.progress) state_next = S_VERDICT;
        else                                     state_next = S_PROC;
      end
      S_VERDICT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load_pair = start && action == ACT_LOAD_PAIR;
        cmd.load_free = start && action == ACT_LOAD_FREE;
      end
      S_INIT: begin
        cmd.init = 1'b1;
      end
      S_PROC: begin
        cmd.r_clear = 1'b1;
      end
      S_FIT_CHK: begin
        if (stat.fits && stat.last_r) cmd.r_clear = 1'b1;
        else if (stat.fits)           cmd.r_inc   = 1'b1;
      end
      S_ADD_WR: begin
        cmd.add_work = 1'b1;
        cmd.r_inc    = !stat.last_r;
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
      end
      S_NEXT: begin
        if (!stat.last_p) cmd.p_inc = 1'b1;
        else              cmd.p_clear = 1'b1;
      end
      S_VERDICT: begin
        cmd.verdict = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// tables, work vector, counters and result registers of the safety check
// ----------------------------------------------------------------------------
module bsc_datapath #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
  parameter int VALUE_WIDTH   = bsc_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bsc_pkg::bsc_cmd_t                   cmd,
  output bsc_pkg::bsc_stat_t                  stat,
  input  logic                                cfg_valid,
  input  logic [bsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [bsc_pkg::PROC_INDEX_W-1:0]    process_index,
  input  logic [bsc_pkg::RES_INDEX_W-1:0]     resource_index,
  input  logic [VALUE_WIDTH-1:0]              held_amount,
  input  logic [VALUE_WIDTH-1:0]              max_claim,
  input  logic [VALUE_WIDTH-1:0]              free_amount,
  output logic                                result_valid,
  output logic [bsc_pkg::PROC_INDEX_W-1:0]    granted_process,
  output logic                                is_verdict,
  output logic                                system_safe,
  output logic                                last_result
);
  import bsc_pkg::*;

  localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW   = $clog2(MAX_PROCESSES + 1);
  localparam int RCW   = $clog2(MAX_RESOURCES + 1);
  localparam int CW    = (VALUE_WIDTH > WORK_W) ? VALUE_WIDTH : WORK_W;

  // configuration
  logic [PROC_COUNT_W-1:0] process_count;
  logic [RES_COUNT_W-1:0]  resource_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= PROC_COUNT_RST;
      resource_count <= RES_COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PROC_COUNT) process_count  <= cfg_data[PROC_COUNT_W-1:0];
      if (cfg_index == CFG_RES_COUNT)  resource_count <= cfg_data[RES_COUNT_W-1:0];
    end
  end

  logic [PCW-1:0] np;
  logic [RCW-1:0] nr;

  assign np = (int'(process_count) > MAX_PROCESSES) ? PCW'(MAX_PROCESSES)
                                                     : PCW'(process_count);
  assign nr = (int'(resource_count) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES)
                                                      : RCW'(resource_count);

  // scan counters and flags
  logic [PIW-1:0]           p;
  logic [RIW-1:0]           r;
  logic [MAX_PROCESSES-1:0] flags;
  logic [PCW-1:0]           fcount;
  logic                     progress;

  always_ff @(posedge clk) begin
    if (rst) begin
      p        <= '0;
      r        <= '0;
      flags    <= '0;
      fcount   <= '0;
      progress <= 1'b0;
    end else begin
      if (cmd.init || cmd.p_clear) p <= '0;
      else if (cmd.p_inc)          p <= p + PIW'(1);
      if (cmd.r_clear)             r <= '0;
      else if (cmd.r_inc)          r <= r + RIW'(1);
      if (cmd.init) begin
        flags  <= '0;
        fcount <= '0;
      end else if (cmd.grant) begin
        flags[p] <= 1'b1;
        fcount   <= fcount + PCW'(1);
      end
      if (cmd.init || cmd.p_clear) progress <= 1'b0;
      else if (cmd.grant)          progress <= 1'b1;
    end
  end

  // held/claim pair memory
  logic [2*VALUE_WIDTH-1:0] pair_mem [DEPTH];
  logic [2*VALUE_WIDTH-1:0] pair_rd;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic                     pair_ok;
  logic                     free_ok;

  assign pair_ok = (int'(process_index) < MAX_PROCESSES) &&
                   (int'(resource_index) < MAX_RESOURCES);
  assign free_ok = (int'(resource_index) < MAX_RESOURCES);
  assign wr_addr = AW'(int'(process_index) * MAX_RESOURCES + int'(resource_index));
  assign rd_addr = AW'(int'(p) * MAX_RESOURCES + int'(r));

  always_ff @(posedge clk) begin
    if (cmd.load_pair && pair_ok) pair_mem[wr_addr] <= {held_amount, max_claim};
    pair_rd <= pair_mem[rd_addr];
  end

  // free counts and work vector
  logic [VALUE_WIDTH-1:0] free_store [MAX_RESOURCES];
  logic [WORK_W-1:0]      work [MAX_RESOURCES];
  logic [VALUE_WIDTH-1:0] held_rd;
  logic [VALUE_WIDTH-1:0] claim_rd;
  logic [VALUE_WIDTH-1:0] need;
  logic [CW:0]            sum;
  logic [WORK_W-1:0]      sum_sat;

  assign held_rd  = pair_rd[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign claim_rd = pair_rd[VALUE_WIDTH-1:0];
  assign need     = (claim_rd > held_rd) ? (claim_rd - held_rd) : '0;
  assign sum      = (CW+1)'(work[r]) + (CW+1)'(held_rd);
  assign sum_sat  = (sum > (CW+1)'(WORK_MAX)) ? WORK_MAX : WORK_W'(sum);

  always_ff @(posedge clk) begin
    if (cmd.load_free && free_ok) free_store[RIW'(resource_index)] <= free_amount;
    if (cmd.init) begin
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        work[i] <= WORK_W'(free_store[i]);
      end
    end else if (cmd.add_work) begin
      work[r] <= sum_sat;
    end
  end

  // status
  assign stat.np_zero  = (np == '0);
  assign stat.nr_zero  = (nr == '0);
  assign stat.flag_set = flags[p];
  assign stat.fits     = (CW'(need) <= CW'(work[r]));
  assign stat.last_p   = ((PCW'(p) + PCW'(1)) == np);
  assign stat.last_r   = ((RCW'(r) + RCW'(1)) == nr);
  assign stat.all_done = (fcount == np);
  assign stat.progress = progress;

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.grant || cmd.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      granted_process <= PROC_INDEX_W'(p);
      is_verdict      <= 1'b0;
      system_safe     <= 1'b0;
      last_result     <= 1'b0;
    end else if (cmd.verdict) begin
      granted_process <= '0;
      is_verdict      <= 1'b1;
      system_safe     <= (fcount == np);
      last_result     <= 1'b1;
    end
  end

endmodule

FILE: rtl/bankers_safety_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_check
// banker's algorithm safety check over loaded held/claim tables
// ----------------------------------------------------------------------------
// usage
//   input word: taken on a clock edge with start high and busy low
//   action load pair writes held/claim of one (process, resource) cell,
//   action load free writes the free count of one resource; neither
//   raises busy, so loads stream one per cycle
//   action check raises busy and walks the tables: a sequence word per
//   process granted in safe order, then one verdict word with last_result
//   result words: result_valid is high for exactly one cycle per word and
//   the word is taken at the edge ending that cycle; there is no stall
//   check steps: a setup state after the accepting edge, then per process
//   visit a process and a next state, plus a memory read and a compare per
//   resource compared, plus on a grant a memory re-read and a work update
//   per resource and a grant state; a grant word is out the cycle after
//   its grant cycle; after the last visit a verdict state, then the verdict
//   word with busy low; the pair memory's single read port sets these steps
//   config: cfg_ready is always high; write only while idle
//   reset: counts return to 16 processes and 8 resources, busy drops;
//   tables hold no defined value until loaded and need no clearing pass
// ----------------------------------------------------------------------------
module bankers_safety_check #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
  parameter int VALUE_WIDTH   = bsc_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [bsc_pkg::ACTION_W-1:0]        action,
  input  logic [bsc_pkg::PROC_INDEX_W-1:0]    process_index,
  input  logic [bsc_pkg::RES_INDEX_W-1:0]     resource_index,
  input  logic [VALUE_WIDTH-1:0]              held_amount,
  input  logic [VALUE_WIDTH-1:0]              max_claim,
  input  logic [VALUE_WIDTH-1:0]              free_amount,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // result channel
  output logic                                result_valid,
  output logic [bsc_pkg::PROC_INDEX_W-1:0]    granted_process,
  output logic                                is_verdict,
  output logic                                system_safe,
  output logic                                last_result
);
  import bsc_pkg::*;

  bsc_cmd_t  cmd;
  bsc_stat_t stat;

  // config registers change only while idle by the user's rule, unenforced by the block; writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  bsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // tables, work vector and result word
  bsc_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .process_index   (process_index),
    .resource_index  (resource_index),
    .held_amount     (held_amount),
    .max_claim       (max_claim),
    .free_amount     (free_amount),
    .result_valid    (result_valid),
    .granted_process (granted_process),
    .is_verdict      (is_verdict),
    .system_safe     (system_safe),
    .last_result     (last_result)
  );

  // a check word always starts a busy run
  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_CHECK |=> busy)
    else $error("check word did not start a run");

  // the verdict is always the closing word
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_verdict |-> last_result)
    else $error("verdict without last marker");

  // sequence words only come out of a running check
  a_grant_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_verdict |-> $past(busy) && !last_result && !system_safe)
    else $error("sequence word outside a check run");

endmodule
